@@ design/dtlv_pkg.sv @@
`timescale 1ns / 1ps
package dtlv_pkg;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN0 = 3'd1,
    PH_LENX = 3'd2,
    PH_BODY = 3'd3,
    PH_HALT = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_HALT = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LEN_LONG = 3'd1;
  localparam logic [2:0] ERR_BOOL_LEN = 3'd2;
  localparam logic [2:0] ERR_BOOL_VAL = 3'd3;
  localparam logic [2:0] ERR_INT_LEN  = 3'd4;
  localparam logic [2:0] ERR_DEEP     = 3'd5;
  localparam logic [2:0] ERR_BS_EMPTY = 3'd6;

  localparam logic [7:0] TAG_BOOL = 8'h01;
  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] TAG_BITS = 8'h03;
  localparam logic [7:0] TAG_OID  = 8'h06;
  localparam logic [7:0] TAG_SEQ  = 8'h30;
  localparam logic [7:0] TAG_SET  = 8'h31;

  localparam logic [32:0] OFF_MAX = 33'h1_FFFF_FFFF;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tag;
    logic [31:0] content_length;
    logic [3:0]  depth;
    logic [31:0] value;
    logic [7:0]  data_byte;
    logic [2:0]  error_code;
    logic [3:0]  closed_count;
    logic        last;
  } res_t;

  function automatic logic [7:0] oid_byte(input logic which, input logic [3:0] pos);
    logic [7:0] b;
    case (pos)
      4'd0: b = 8'h60;
      4'd1: b = 8'h86;
      4'd2: b = 8'h48;
      4'd3: b = 8'h01;
      4'd4: b = 8'h65;
      4'd5: b = 8'h03;
      4'd6: b = 8'h04;
      4'd7: b = 8'h01;
      4'd8: b = which ? 8'h2D : 8'h2A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/der_tlv_stream_parser.sv @@
`timescale 1ns / 1ps
// DER tag-length-value stream parser.
// Input channel: one byte of a DER encoding per word; in_tuser is start_req,
// which clears all parser state before that byte is taken as a first tag.
// Output channel: one result word per finished element, per opened container,
// per bit string data byte, or one fatal word (kind 2) on a too-long length or
// too-deep nesting. out_tlast marks the final result caused by one input byte.
// Throughput is one byte per cycle while the queue has room for two words: the
// byte is decoded in a single pass (tag, length, value accumulate, and a parallel
// compare of the running offset against all container end offsets) and its
// results are registered into a four-word queue.
// A byte can produce two results; the input is taken only while the queue has
// room for two, so a stalled receiver backs up into in_tready once three words
// are waiting.
// Reset (synchronous, rst_n low) clears parser state and empties the queue.
// After a fatal error every byte is accepted and dropped until start_req.
module der_tlv_stream_parser #(
  parameter int MAX_DEPTH     = 8,
  parameter int MAX_LEN_BYTES = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] in_byte
  input  logic         in_tuser,   // [0] start_req
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] kind, [9:2] tag, [41:10] content_length, [45:42] depth,
  // [77:46] value, [85:78] data_byte, [88:86] error_code, [92:89] closed_count
  output logic [95:0]  out_tdata,
  output logic         out_tlast
);
  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  dtlv_pkg::phase_t phase_r, phase_nxt;
  logic [32:0] off_r, off_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [2:0]  lbl_r, lbl_nxt;
  logic [31:0] cl_r, cl_nxt;
  logic [31:0] va_r, va_nxt;
  logic [1:0]  om_r, om_nxt;
  logic [DW-1:0] dep_r, dep_nxt;
  logic [32:0] ends_r [MAX_DEPTH];
  logic        push_en;
  logic [AW-1:0] push_idx;
  logic [32:0] push_val;

  logic [1:0]  push_cnt;
  dtlv_pkg::res_t r0, r1, fo;
  logic [2:0]  free_cnt;
  logic        acc;

  assign in_tready = (free_cnt >= 3'd2);
  assign acc = in_tvalid && in_tready;

  dtlv_out_fifo u_fifo (
    .clk, .rst_n, .push_cnt(acc ? push_cnt : 2'd0), .push0(r0), .push1(r1),
    .free_cnt, .pop_valid(out_tvalid), .pop_ready(out_tready), .pop_data(fo)
  );

  assign out_tdata = {3'b0, fo.closed_count, fo.error_code, fo.data_byte, fo.value,
                      fo.depth, fo.content_length, fo.tag, fo.kind};
  assign out_tlast = fo.last;

  // Combinational single pass.
  always_comb begin
    logic [7:0]  b;
    logic        st;
    dtlv_pkg::phase_t ph;
    logic [32:0] off, off1, endv;
    logic [7:0]  tg;
    logic [31:0] ln, cl, va, pos, v, len_h, lacc;
    logic [1:0]  om;
    logic [DW-1:0] dp, cdep;
    logic [3:0]  closed;
    logic [2:0]  err;
    logic [6:0]  nlen;
    logic        hdr, fin, cont;
    dtlv_pkg::res_t rr;

    b  = in_tdata;
    st = in_tuser;
    ph = st ? dtlv_pkg::PH_TAG : phase_r;
    off = st ? 33'd0 : off_r;
    tg = st ? 8'd0 : tag_r;
    ln = st ? 32'd0 : len_r;
    lbl_nxt = st ? 3'd0 : lbl_r;
    cl = st ? 32'd0 : cl_r;
    va = st ? 32'd0 : va_r;
    om = st ? 2'b11 : om_r;
    dp = st ? '0 : dep_r;
    push_cnt = 2'd0;
    r0 = '0; r1 = '0;
    push_en = 1'b0; push_idx = AW'(dp); push_val = '0;
    hdr = 1'b0; fin = 1'b0; len_h = 32'd0; lacc = 32'd0;
    off1 = (off < dtlv_pkg::OFF_MAX) ? off + 33'd1 : off;
    closed = 4'd0; cdep = dp; endv = '0;
    err = dtlv_pkg::ERR_NONE; v = 32'd0; nlen = b[6:0]; pos = ln - cl;
    cont = 1'b0; rr = '0;

    if (ph != dtlv_pkg::PH_HALT) off = off1;

    case (ph)
      dtlv_pkg::PH_TAG: begin
        tg = b; ln = 32'd0; cl = 32'd0; va = 32'd0; om = 2'b11;
        ph = dtlv_pkg::PH_LEN0;
      end
      dtlv_pkg::PH_LEN0: begin
        if (!b[7]) begin
          hdr = 1'b1; len_h = {24'd0, b};
        end else if (nlen > 7'(MAX_LEN_BYTES)) begin
          r0.kind = dtlv_pkg::KIND_HALT; r0.tag = tg; r0.content_length = ln;
          r0.depth = 4'(dp); r0.error_code = dtlv_pkg::ERR_LEN_LONG; r0.last = 1'b1;
          push_cnt = 2'd1; ph = dtlv_pkg::PH_HALT;
        end else if (nlen == 7'd0) begin
          hdr = 1'b1; len_h = 32'd0;
        end else begin
          lbl_nxt = nlen[2:0]; ln = 32'd0; ph = dtlv_pkg::PH_LENX;
        end
      end
      dtlv_pkg::PH_LENX: begin
        lacc = {ln[23:0], b}; ln = lacc;
        if (lbl_nxt != 3'd0) lbl_nxt = lbl_nxt - 3'd1;
        if (lbl_nxt == 3'd0) begin hdr = 1'b1; len_h = lacc; end
      end
      dtlv_pkg::PH_BODY: begin
        case (tg)
          dtlv_pkg::TAG_BOOL: if (pos == 32'd0) va = {24'd0, b};
          dtlv_pkg::TAG_INT:  va = {va[23:0], b};
          dtlv_pkg::TAG_OID: begin
            if (pos < 32'd9) begin
              if (dtlv_pkg::oid_byte(1'b0, pos[3:0]) != b) om[0] = 1'b0;
              if (dtlv_pkg::oid_byte(1'b1, pos[3:0]) != b) om[1] = 1'b0;
            end
          end
          dtlv_pkg::TAG_BITS: begin
            if (pos == 32'd0) va = {24'd0, b};
            else begin
              r0.kind = dtlv_pkg::KIND_DATA; r0.tag = tg; r0.content_length = ln;
              r0.depth = 4'(dp); r0.value = {24'd0, va[7:0]}; r0.data_byte = b;
              r0.last = (cl != 32'd1); push_cnt = 2'd1;
            end
          end
          default: ;
        endcase
        if (cl != 32'd0) cl = cl - 32'd1;
        if (cl == 32'd0) fin = 1'b1;
      end
      default: ph = dtlv_pkg::PH_HALT;
    endcase

    if (hdr) begin
      ln = len_h; cl = len_h;
      if (tg == dtlv_pkg::TAG_SEQ || tg == dtlv_pkg::TAG_SET) begin
        cont = 1'b1;
        if (32'(dp) >= 32'(MAX_DEPTH)) begin
          r0.kind = dtlv_pkg::KIND_HALT; r0.tag = tg; r0.content_length = ln;
          r0.depth = 4'(dp); r0.error_code = dtlv_pkg::ERR_DEEP; r0.last = 1'b1;
          push_cnt = 2'd1; ph = dtlv_pkg::PH_HALT;
        end else begin
          endv = off + {1'b0, len_h};
          if (endv < off) endv = dtlv_pkg::OFF_MAX;
          push_en = 1'b1; push_idx = AW'(dp); push_val = endv;
          cdep = dp + DW'(1);
          r0.kind = dtlv_pkg::KIND_DONE; r0.tag = tg; r0.content_length = ln;
          r0.depth = 4'(dp); r0.last = 1'b1;
          push_cnt = 2'd1; ph = dtlv_pkg::PH_TAG;
        end
      end else if (len_h == 32'd0) begin
        fin = 1'b1;
      end else begin
        ph = dtlv_pkg::PH_BODY;
      end
    end

    // Pop count: entries closing are a contiguous top run; count from the top.
    // A container opened by this byte is compared as the new top entry.
    if (fin || (cont && push_en)) begin
      if (fin) cdep = dp;
      closed = 4'd0;
      for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
        if (32'(i) < 32'(cdep) && 32'(i) == 32'(cdep) - 32'd1 - 32'(closed)) begin
          if (off >= ((push_en && AW'(i) == push_idx) ? push_val : ends_r[i]))
            closed = closed + 4'd1;
        end
      end
    end

    if (fin) begin
      case (tg)
        dtlv_pkg::TAG_BOOL: begin
          if (ln != 32'd1) err = dtlv_pkg::ERR_BOOL_LEN;
          else begin
            v = (va[7:0] != 8'd0) ? 32'd1 : 32'd0;
            if (va[7:0] != 8'd0 && va[7:0] != 8'hFF) err = dtlv_pkg::ERR_BOOL_VAL;
          end
        end
        dtlv_pkg::TAG_INT: begin
          if (ln == 32'd0 || ln > 32'd4) err = dtlv_pkg::ERR_INT_LEN;
          else begin
            case (ln[2:0])
              3'd1: v = {{24{va[7]}}, va[7:0]};
              3'd2: v = {{16{va[15]}}, va[15:0]};
              3'd3: v = {{8{va[23]}}, va[23:0]};
              default: v = va;
            endcase
          end
        end
        dtlv_pkg::TAG_BITS: begin
          if (ln == 32'd0) err = dtlv_pkg::ERR_BS_EMPTY;
          else v = {24'd0, va[7:0]};
        end
        dtlv_pkg::TAG_OID: begin
          if (ln == 32'd9) begin
            if (om[0]) v = 32'd1;
            else if (om[1]) v = 32'd2;
          end
        end
        default: ;
      endcase
      rr.kind = dtlv_pkg::KIND_DONE; rr.tag = tg; rr.content_length = ln;
      rr.depth = 4'(dp); rr.value = v; rr.error_code = err;
      rr.closed_count = closed; rr.last = 1'b1;
      if (push_cnt == 2'd1) begin r1 = rr; push_cnt = 2'd2; end
      else begin r0 = rr; push_cnt = 2'd1; end
      ph = dtlv_pkg::PH_TAG;
    end else if (cont && push_en) begin
      r0.closed_count = closed;
    end

    phase_nxt = ph; off_nxt = off; tag_nxt = tg; len_nxt = ln; cl_nxt = cl;
    va_nxt = va; om_nxt = om;
    dep_nxt = (cont && push_en) ? cdep - DW'(closed) : (fin ? dp - DW'(closed) : dp);
  end

  always_ff @(posedge clk) begin
    if (acc && push_en) ends_r[push_idx] <= push_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= dtlv_pkg::PH_TAG;
      off_r <= '0; tag_r <= '0; len_r <= '0; lbl_r <= '0; cl_r <= '0;
      va_r <= '0; om_r <= 2'b11; dep_r <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt; off_r <= off_nxt; tag_r <= tag_nxt; len_r <= len_nxt;
      lbl_r <= lbl_nxt; cl_r <= cl_nxt; va_r <= va_nxt; om_r <= om_nxt;
      dep_r <= dep_nxt;
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(dep_r) <= 32'(MAX_DEPTH)) else $error("open depth over limit");
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && phase_r == dtlv_pkg::PH_HALT && !in_tuser) |=> $stable(dep_r))
    else $error("halted parser changed state");
  a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3) else $error("bad result kind");
endmodule

@@ design/dtlv_out_fifo.sv @@
`timescale 1ns / 1ps
// Small result queue; up to two words pushed per cycle, one popped.
module dtlv_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  dtlv_pkg::res_t     push0,
  input  dtlv_pkg::res_t     push1,
  output logic [2:0]         free_cnt,
  output logic               pop_valid,
  input  logic               pop_ready,
  output dtlv_pkg::res_t     pop_data
);
  dtlv_pkg::res_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       pop;
  logic [1:0] wp1;

  assign pop       = pop_valid && pop_ready;
  assign pop_valid = (cnt_r != 3'd0);
  assign pop_data  = mem_r[rp_r];
  assign free_cnt  = 3'd4 - cnt_r;
  assign wp1       = wp_r + 2'd1;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wp_r] <= push0;
    if (push_cnt == 2'd2) mem_r[wp1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_cnt;
      if (pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, push_cnt} - {2'b0, pop};
    end
  end
endmodule
